[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and codes of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 48;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_DELETE   = 3'd1;
    localparam logic [2:0] MODE_RETRIEVE = 3'd2;
    localparam logic [2:0] MODE_REPLACE  = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;
    localparam logic [2:0] MODE_TRAVERSE = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [31:0] value_in;
        logic [4:0]  position;
        logic [2:0]  mode;
    } cmd_t;

    typedef struct packed {
        logic        last;
        logic        is_empty;
        logic        is_full;
        logic [4:0]  count;
        logic [1:0]  status;
        logic [31:0] value_out;
    } res_t;

endpackage

[hdl/ple_ram.sv]
// ----------------------------------------------------------------------------
// ple_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// command sequencer: moves entries one at a time through the entry ram
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  ple_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output ple_pkg::res_t res
);

    import ple_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]            state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic [AW-1:0]         ptr_reg,    ptr_next;
    logic [AW-1:0]         pos_reg,    pos_next;
    logic [2:0]            mode_reg,   mode_next;
    logic [DATA_WIDTH-1:0] val_reg,    val_next;
    logic [1:0]            status_reg, status_next;
    logic                  last_reg,   last_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [AW-1:0]         ptr_up;
    logic [AW-1:0]         ptr_dn;
    logic [CNT_W-1:0]      ptr_inc;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  list_full;
    logic                  list_empty;

    // shared pointer unit
    assign ptr_up     = ptr_reg + AW'(1);
    assign ptr_dn     = ptr_reg - AW'(1);
    assign ptr_inc    = CNT_W'(ptr_reg) + CNT_W'(1);
    assign pos_ext    = CMP_W'(cmd.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);

    assign mem_re = (state_reg == S_RD) || (state_reg == S_SH_RD);

    ple_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        mode_next   = mode_reg;
        val_next    = val_reg;
        status_next = status_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = val_reg;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    mode_next   = cmd.mode;
                    pos_next    = AW'(cmd.position);
                    val_next    = '0;
                    status_next = STAT_OK;
                    last_next   = 1'b1;
                    state_next  = S_EMIT;
                    unique case (cmd.mode) inside
                        MODE_INSERT:
                        begin
                            if (list_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                val_next = DATA_WIDTH'(cmd.value_in);
                                if (pos_ext == cnt_ext)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    ptr_next   = AW'(count_reg - CNT_W'(1));
                                    state_next = S_SH_RD;
                                end
                            end
                        end
                        MODE_DELETE, MODE_RETRIEVE, MODE_REPLACE:
                        begin
                            if (list_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (cmd.mode == MODE_REPLACE)
                            begin
                                val_next   = DATA_WIDTH'(cmd.value_in);
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ptr_next   = AW'(cmd.position);
                                state_next = S_RD;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_TRAVERSE:
                        begin
                            if (list_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                val_next   = mem_rdata;
                state_next = S_EMIT;
                if (mode_reg == MODE_DELETE)
                begin
                    if (ptr_inc == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        ptr_next   = ptr_up;
                        state_next = S_SH_RD;
                    end
                end
                else if (mode_reg == MODE_TRAVERSE)
                begin
                    last_next = (ptr_inc == count_reg);
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (mode_reg == MODE_DELETE)
                begin
                    // shift down: entry at ptr moves to ptr - 1
                    mem_waddr = ptr_dn;
                    if (ptr_inc == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ptr_next   = ptr_up;
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    // shift up: entry at ptr moves to ptr + 1
                    mem_waddr = ptr_up;
                    if (ptr_reg == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ptr_next   = ptr_dn;
                        state_next = S_SH_RD;
                    end
                end
            end
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = val_reg;
                val_next  = '0;
                if (mode_reg == MODE_INSERT)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if ((mode_reg == MODE_TRAVERSE) && !last_reg)
                    begin
                        ptr_next   = ptr_up;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign res.value_out = 32'(val_reg);
    assign res.status    = status_reg;
    assign res.count     = 5'(count_reg);
    assign res.is_full   = list_full;
    assign res.is_empty  = list_empty;
    assign res.last      = last_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_no_write_idle, clk, rst_n, mem_we, !cmd_ready)
    `ASSERT_IMPLIES(a_notlast_traverse, clk, rst_n, res_valid && !res.last, mode_reg == MODE_TRAVERSE)
    `ASSERT_IMPLIES(a_insert_ok_count, clk, rst_n, res_valid && (mode_reg == MODE_INSERT) && (res.status == STAT_OK), !list_empty)

endmodule

[hdl/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of up to DEPTH entries addressed by position
// ----------------------------------------------------------------------------
// commands arrive as words on the s_ side: mode, position and value_in.
// results leave as words on the m_ side; m_tlast marks the final result of
// a command. traverse gives one word per entry (one word with the empty
// status on an empty list); every other mode gives exactly one word.
// one command is in work at a time and s_tready stays low until its last
// result has been handed to the output register.
// entries moved per command, n entries, position p:
//   insert n - p, delete n - p - 1; retrieve, replace, clear and refused
//   commands move none, and traverse reads every entry once.
// the entry ram has one read and one write port, so every moved entry is
// read in one step and written back in a separate step.
// reset empties the list; entry contents are not cleared and no sweep runs.
// when m_tready is low the result word holds in the output register and the
// sequencer waits before producing its next word.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode[2:0], position[7:3], value_in[39:8]
    input  logic [ple_pkg::TDATA_IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // value_out[31:0], status[33:32], count[38:34], is_full[39], is_empty[40]
    output logic [ple_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    import ple_pkg::*;

    cmd_t cmd;
    res_t res;
    logic res_valid;
    logic res_ready;

    logic out_valid_reg, out_valid_next;
    res_t out_reg,       out_next;

    assign cmd.mode     = s_tdata[2:0];
    assign cmd.position = s_tdata[7:3];
    assign cmd.value_in = s_tdata[39:8];

    ple_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.is_empty, out_reg.is_full, out_reg.count,
                       out_reg.status, out_reg.value_out};

endmodule
